@@ hdl/lrp_pkg.sv @@
package lrp_pkg;

    // default worker capacity of the snapshot store
    localparam int WORKERS_DEF = 32;

    // depth of the item queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // commands per run, not counting the done command
    localparam int MAX_CMDS  = 32;
    localparam int CMD_CNT_W = 6;

    localparam int LOAD_W = 16;
    localparam int IDX_W  = 5;

    // command kinds
    localparam logic [1:0] KIND_ALL  = 2'd0;
    localparam logic [1:0] KIND_HALF = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_IDLE     = 2'd0;
    localparam logic [1:0] REG_ACCEPT   = 2'd1;
    localparam logic [1:0] REG_OVERLOAD = 2'd2;

    // reset values of the thresholds
    localparam logic [LOAD_W-1:0] IDLE_RST     = 16'd6554;
    localparam logic [LOAD_W-1:0] ACCEPT_RST   = 16'd19661;
    localparam logic [LOAD_W-1:0] OVERLOAD_RST = 16'd29491;

    typedef struct packed {
        logic [LOAD_W-1:0] idle;
        logic [LOAD_W-1:0] accept;
        logic [LOAD_W-1:0] overload;
    } thr_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dst;
        logic             last;
    } cmd_t;

endpackage

@@ hdl/load_rebalance_planner_core.sv @@
// channel  | dir | handshake                     | payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata[15:0] load level, tlast last_worker
// m_axis   | out | m_axis_tvalid / m_axis_tready | tuser command_kind, tdata src/dst, tlast
// cfg      | in  | cfg_we (no wait)              | cfg_addr register index, cfg_wdata value
//
// loads are taken one per cycle into a four-entry queue, stored one per cycle while the
// back end collects; after the last load a scan reads then classes each worker, then up
// to 2*WORKERS walk steps read then evaluate, plus an output state when a command issues;
// each store has one read port; the done command closes every run; reset needs no
// clearing pass; a stalled m_axis holds the walk, a full queue holds s_axis
module load_rebalance_planner_core #(
    parameter int WORKERS = lrp_pkg::WORKERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] load level
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] source_worker, [9:5] dest_worker, zero fill
    output logic [1:0]  m_axis_tuser,   // [1:0] command_kind
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int ITEM_W = lrp_pkg::LOAD_W + 2 + $clog2(WORKERS) + $clog2(WORKERS + 1);

    lrp_pkg::thr_t     thr_reg;
    lrp_pkg::thr_t     thr_next;
    logic [ITEM_W-1:0] front_item;
    logic [ITEM_W-1:0] q_item;
    logic              q_valid;
    logic              q_ready;
    logic              out_valid;
    lrp_pkg::cmd_t     out_cmd;

    // threshold registers
    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                lrp_pkg::REG_IDLE:     thr_next.idle     = cfg_wdata;
                lrp_pkg::REG_ACCEPT:   thr_next.accept   = cfg_wdata;
                lrp_pkg::REG_OVERLOAD: thr_next.overload = cfg_wdata;
                default:               thr_next          = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.idle     <= lrp_pkg::IDLE_RST;
            thr_reg.accept   <= lrp_pkg::ACCEPT_RST;
            thr_reg.overload <= lrp_pkg::OVERLOAD_RST;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    // input tagging
    lrp_front #(.WORKERS(WORKERS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_load  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .item     (front_item)
    );

    // decoupling queue
    lrp_queue #(.WIDTH(ITEM_W), .DEPTH(lrp_pkg::QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_data  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_item)
    );

    // storage and planning
    lrp_back #(.WORKERS(WORKERS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .thr       (thr_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (m_axis_tready),
        .out_cmd   (out_cmd)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = out_cmd.kind;
    assign m_axis_tdata  = {6'd0, out_cmd.dst, out_cmd.src};
    assign m_axis_tlast  = out_cmd.last;

endmodule

@@ hdl/lrp_ram.sv @@
module lrp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/lrp_front.sv @@
module lrp_front #(
    parameter int WORKERS = lrp_pkg::WORKERS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic [lrp_pkg::LOAD_W-1:0]             in_load,
    input  logic                                   in_last,
    input  logic                                   in_ready,
    output logic [lrp_pkg::LOAD_W+2+$clog2(WORKERS)+$clog2(WORKERS+1)-1:0] item
);

    localparam int IW = $clog2(WORKERS);
    localparam int CW = $clog2(WORKERS + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          store;
    logic [CW-1:0] fill;

    // loads past the store capacity are tagged as not stored
    assign store = (count_reg < CW'(WORKERS));
    assign fill  = store ? count_reg + CW'(1) : count_reg;

    // item: {fill count, write address, store, last, load}
    assign item = {fill, count_reg[IW-1:0], store, in_last, in_load};

    // count restarts after the transfer that closes a snapshot
    always_comb
    begin
        count_next = count_reg;
        if (in_valid && in_ready)
        begin
            count_next = in_last ? '0 : fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/lrp_queue.sv @@
module lrp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lrp_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg;
    logic [PW-1:0]    wptr_next;
    logic [PW-1:0]    rptr_reg;
    logic [PW-1:0]    rptr_next;
    logic [NW-1:0]    used_reg;
    logic [NW-1:0]    used_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (used_reg != NW'(DEPTH));
    assign pop_valid  = (used_reg != '0);
    assign pop_data   = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer wrap and fill level
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        used_next = used_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            used_next = used_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            used_next = used_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            used_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            used_reg <= used_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/lrp_back.sv @@
module lrp_back #(
    parameter int WORKERS = lrp_pkg::WORKERS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrp_pkg::thr_t        thr,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [lrp_pkg::LOAD_W+2+$clog2(WORKERS)+$clog2(WORKERS+1)-1:0] q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lrp_pkg::cmd_t        out_cmd
);

    localparam int IW = $clog2(WORKERS);
    localparam int CW = $clog2(WORKERS + 1);
    localparam int LW = lrp_pkg::LOAD_W;
    localparam int XW = lrp_pkg::IDX_W;
    localparam int NC = lrp_pkg::CMD_CNT_W;

    localparam logic [2:0] ST_COLLECT  = 3'd0;
    localparam logic [2:0] ST_SCAN_RD  = 3'd1;
    localparam logic [2:0] ST_SCAN_EV  = 3'd2;
    localparam logic [2:0] ST_WALK_RD  = 3'd3;
    localparam logic [2:0] ST_WALK_EV  = 3'd4;
    localparam logic [2:0] ST_WALK_OUT = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] n_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic          second_reg;
    logic          second_next;
    logic [CW-1:0] idle_depth_reg;
    logic [CW-1:0] idle_depth_next;
    logic [CW-1:0] ovl_depth_reg;
    logic [CW-1:0] ovl_depth_next;
    logic          any_avail_reg;
    logic          any_avail_next;
    logic          any_split_reg;
    logic          any_split_next;
    logic [1:0]    kind_reg;
    logic [1:0]    kind_next;
    logic [NC-1:0] cmd_cnt_reg;
    logic [NC-1:0] cmd_cnt_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    lrp_pkg::cmd_t out_cmd_reg;
    lrp_pkg::cmd_t out_cmd_next;

    // queued item fields
    logic [LW-1:0] it_load;
    logic          it_last;
    logic          it_store;
    logic [IW-1:0] it_waddr;
    logic [CW-1:0] it_fill;

    assign {it_fill, it_waddr, it_store, it_last, it_load} = q_item;

    // memories
    logic [LW-1:0] load_rdata;
    logic [XW-1:0] idle_rdata;
    logic [XW-1:0] ovl_rdata;
    logic          idle_we;
    logic          ovl_we;
    logic [CW-1:0] idle_top;
    logic [CW-1:0] ovl_top;
    logic [XW-1:0] idx5;
    logic [IW+XW-1:0] idx_ext;

    // worker index as a 5-bit command field
    assign idx_ext = {{XW{1'b0}}, idx_reg[IW-1:0]};
    assign idx5    = idx_ext[XW-1:0];

    // popped entry stays on the read port while a command waits
    assign idle_top = (state_reg == ST_WALK_OUT) ? idle_depth_reg : idle_depth_reg - CW'(1);
    assign ovl_top  = (state_reg == ST_WALK_OUT) ? ovl_depth_reg : ovl_depth_reg - CW'(1);

    lrp_ram #(.WIDTH(LW), .DEPTH(WORKERS)) u_load_ram (
        .clk   (clk),
        .we    (q_ready && q_valid && it_store),
        .waddr (it_waddr),
        .wdata (it_load),
        .raddr (idx_reg[IW-1:0]),
        .rdata (load_rdata)
    );

    lrp_ram #(.WIDTH(XW), .DEPTH(WORKERS)) u_idle_stack (
        .clk   (clk),
        .we    (idle_we),
        .waddr (idle_depth_reg[IW-1:0]),
        .wdata (idx5),
        .raddr (idle_top[IW-1:0]),
        .rdata (idle_rdata)
    );

    lrp_ram #(.WIDTH(XW), .DEPTH(WORKERS)) u_ovl_stack (
        .clk   (clk),
        .we    (ovl_we),
        .waddr (ovl_depth_reg[IW-1:0]),
        .wdata (idx5),
        .raddr (ovl_top[IW-1:0]),
        .rdata (ovl_rdata)
    );

    // classes of the load just read
    logic is_idle;
    logic is_host;
    logic is_over;
    logic is_mid;
    logic at_end;
    logic walk_end;
    logic out_free;

    assign is_idle  = (load_rdata <= thr.idle);
    assign is_host  = (load_rdata <= thr.accept);
    assign is_over  = (load_rdata >= thr.overload);
    assign is_mid   = !is_idle && !is_over;
    assign at_end   = (idx_reg + CW'(1) == n_reg);
    assign walk_end = at_end && second_reg;
    assign out_free = !out_valid_reg || out_ready;

    assign idle_we = (state_reg == ST_SCAN_EV) && is_idle;
    assign ovl_we  = (state_reg == ST_SCAN_EV) && !is_idle && is_over;

    assign q_ready   = (state_reg == ST_COLLECT);
    assign out_valid = out_valid_reg;
    assign out_cmd   = out_cmd_reg;

    // planning sequencer
    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        second_next     = second_reg;
        idle_depth_next = idle_depth_reg;
        ovl_depth_next  = ovl_depth_reg;
        any_avail_next  = any_avail_reg;
        any_split_next  = any_split_reg;
        kind_next       = kind_reg;
        cmd_cnt_next    = cmd_cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_cmd_next    = out_cmd_reg;

        case (state_reg)
            ST_COLLECT:
            begin
                if (q_valid && it_last)
                begin
                    n_next          = it_fill;
                    idx_next        = '0;
                    second_next     = 1'b0;
                    idle_depth_next = '0;
                    ovl_depth_next  = '0;
                    any_avail_next  = 1'b0;
                    any_split_next  = 1'b0;
                    cmd_cnt_next    = '0;
                    state_next      = ST_SCAN_RD;
                end
            end

            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_EV;
            end

            // class the worker, push candidates, note whether planning is needed
            ST_SCAN_EV:
            begin
                if (is_idle)
                begin
                    idle_depth_next = idle_depth_reg + CW'(1);
                end
                else if (is_over)
                begin
                    ovl_depth_next = ovl_depth_reg + CW'(1);
                end
                any_avail_next = any_avail_reg || is_host || is_idle;
                any_split_next = any_split_reg || (!is_idle && !is_host && is_over);
                if (at_end)
                begin
                    idx_next = '0;
                    if (any_avail_next && any_split_next)
                    begin
                        state_next = ST_WALK_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_WALK_RD:
            begin
                state_next = ST_WALK_EV;
            end

            // pick a candidate for this worker, move on, or end the walk
            ST_WALK_EV:
            begin
                if (is_mid && idle_depth_reg != '0)
                begin
                    idle_depth_next = idle_depth_reg - CW'(1);
                    kind_next       = lrp_pkg::KIND_ALL;
                    state_next      = ST_WALK_OUT;
                end
                else if ((is_mid || is_idle) && ovl_depth_reg != '0)
                begin
                    ovl_depth_next = ovl_depth_reg - CW'(1);
                    kind_next      = lrp_pkg::KIND_HALF;
                    state_next     = ST_WALK_OUT;
                end
                else if (is_mid || walk_end)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next    = at_end ? '0 : idx_reg + CW'(1);
                    second_next = second_reg || at_end;
                    state_next  = ST_WALK_RD;
                end
            end

            // popped candidate is on the stack read port
            ST_WALK_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_cmd_next.kind = kind_reg;
                    out_cmd_next.src  = (kind_reg == lrp_pkg::KIND_ALL) ? idle_rdata
                                                                         : ovl_rdata;
                    out_cmd_next.dst  = idx5;
                    out_cmd_next.last = 1'b0;
                    cmd_cnt_next      = cmd_cnt_reg + NC'(1);
                    if (walk_end || cmd_cnt_next == NC'(lrp_pkg::MAX_CMDS))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next    = at_end ? '0 : idx_reg + CW'(1);
                        second_next = second_reg || at_end;
                        state_next  = ST_WALK_RD;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_cmd_next.kind = lrp_pkg::KIND_DONE;
                    out_cmd_next.src  = '0;
                    out_cmd_next.dst  = '0;
                    out_cmd_next.last = 1'b1;
                    state_next        = ST_COLLECT;
                end
            end

            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            n_reg          <= '0;
            idx_reg        <= '0;
            second_reg     <= 1'b0;
            idle_depth_reg <= '0;
            ovl_depth_reg  <= '0;
            any_avail_reg  <= 1'b0;
            any_split_reg  <= 1'b0;
            kind_reg       <= lrp_pkg::KIND_ALL;
            cmd_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            idx_reg        <= idx_next;
            second_reg     <= second_next;
            idle_depth_reg <= idle_depth_next;
            ovl_depth_reg  <= ovl_depth_next;
            any_avail_reg  <= any_avail_next;
            any_split_reg  <= any_split_next;
            kind_reg       <= kind_next;
            cmd_cnt_reg    <= cmd_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_cmd_reg <= out_cmd_next;
    end

endmodule

@@ hdl/lrp_checker.sv @@
module lrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic [lrp_pkg::CMD_CNT_W-1:0] run_cnt_reg;
    logic [lrp_pkg::CMD_CNT_W-1:0] run_cnt_next;

    // moves seen since the last done command
    always_comb
    begin
        run_cnt_next = run_cnt_reg;
        if (m_axis_tvalid && m_axis_tready)
        begin
            run_cnt_next = m_axis_tlast ? '0 : run_cnt_reg + lrp_pkg::CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= '0;
        end
        else
        begin
            run_cnt_reg <= run_cnt_next;
        end
    end

    // a stalled command holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("command changed while stalled");

    // done and only done closes a run, with zero indexes
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == lrp_pkg::KIND_DONE))
            && (!m_axis_tlast || m_axis_tdata == 16'd0))
        else $error("done command and last mark disagree");

    // no command kind beyond done
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == lrp_pkg::KIND_ALL)
            || (m_axis_tuser == lrp_pkg::KIND_HALF) || (m_axis_tuser == lrp_pkg::KIND_DONE))
        else $error("illegal command kind");

    // a run carries at most the capped number of moves
    a_run_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> run_cnt_reg < lrp_pkg::CMD_CNT_W'(lrp_pkg::MAX_CMDS))
        else $error("too many moves in one run");

endmodule

bind load_rebalance_planner_core lrp_checker u_lrp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
